// File: hdl/stld_pkg.sv
// Shared types and constants of the sync/type/length deframer.
// No dependencies; every module of the block imports this package.
package stld_pkg;

	// Result kinds as they appear on the kind port.
	localparam logic [1:0] KIND_DATA     = 2'd0;
	localparam logic [1:0] KIND_EMPTY    = 2'd1;
	localparam logic [1:0] KIND_SYNC_ERR = 2'd2;
	localparam logic [1:0] KIND_LEN_ERR  = 2'd3;

	// Configuration register indexes.
	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_SYNC_VALUE   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LENGTH_LIMIT = 2'd1;

	// Register reset values.
	localparam logic [7:0]  SYNC_VALUE_RST   = 8'h00;
	localparam logic [31:0] LENGTH_LIMIT_RST = 32'd65536;

	// One configuration write as seen by the front end.
	typedef struct packed {
		logic                   valid;
		logic [CFG_INDEX_W-1:0] index;
		logic [31:0]            data;
	} cfg_wr_t;

	// One result item as it travels through the queue.
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  frame_type;
		logic [7:0]  payload_byte;
		logic        last_of_frame;
		logic [31:0] frame_length;
	} result_t;

endpackage

// File: hdl/stld_front.sv
// Front end of the deframer: takes stream bytes, tracks the frame header
// and produces at most one result item per byte. Depends on stld_pkg.
module stld_front #(
	parameter int LENGTH_BYTES = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  stld_pkg::cfg_wr_t cfg_wr,
	input  logic             in_valid,
	input  logic             full,
	input  logic [7:0]       data_byte,
	output logic             push,
	output stld_pkg::result_t push_item
);
	import stld_pkg::*;

	localparam int LIDX_W = (LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1;
	localparam logic [LIDX_W-1:0] LAST_IDX = LIDX_W'(LENGTH_BYTES - 1);

	typedef enum logic [3:0] {
		ST_HUNT    = 4'b0001,
		ST_TYPE    = 4'b0010,
		ST_LEN     = 4'b0100,
		ST_PAYLOAD = 4'b1000
	} state_t;

	state_t            state_q, state_d;
	logic [7:0]        sync_value_q;
	logic [31:0]       length_limit_q;
	logic [7:0]        held_type_q, held_type_d;
	logic [31:0]       held_length_q, held_length_d;
	logic [31:0]       bytes_left_q, bytes_left_d;
	logic [LIDX_W-1:0] len_idx_q, len_idx_d;
	logic [31:0]       len_new;
	logic              accept;

	// A byte is taken whenever the queue has room.
	assign accept = in_valid && !full;

	// Length with the current byte merged in at its byte position.
	assign len_new = held_length_q | ({24'd0, data_byte} << {len_idx_q, 3'b000});

	// Header tracking and result classification.
	always_comb begin
		state_d       = state_q;
		held_type_d   = held_type_q;
		held_length_d = held_length_q;
		bytes_left_d  = bytes_left_q;
		len_idx_d     = len_idx_q;
		push          = 1'b0;
		push_item     = '0;
		case (state_q)
			ST_TYPE: begin
				held_type_d   = data_byte;
				held_length_d = '0;
				len_idx_d     = '0;
				state_d       = ST_LEN;
			end
			ST_LEN: begin
				held_length_d = len_new;
				if (len_idx_q != LAST_IDX) begin
					len_idx_d = len_idx_q + 1'b1;
				end else if (len_new >= length_limit_q) begin
					push                   = 1'b1;
					push_item.kind         = KIND_LEN_ERR;
					push_item.frame_type   = held_type_q;
					push_item.frame_length = len_new;
					state_d                = ST_HUNT;
				end else if (len_new == '0) begin
					push                    = 1'b1;
					push_item.kind          = KIND_EMPTY;
					push_item.frame_type    = held_type_q;
					push_item.last_of_frame = 1'b1;
					state_d                 = ST_HUNT;
				end else begin
					bytes_left_d = len_new;
					state_d      = ST_PAYLOAD;
				end
			end
			ST_PAYLOAD: begin
				push                    = 1'b1;
				push_item.kind          = KIND_DATA;
				push_item.frame_type    = held_type_q;
				push_item.payload_byte  = data_byte;
				push_item.frame_length  = held_length_q;
				push_item.last_of_frame = (bytes_left_q <= 32'd1);
				if (bytes_left_q <= 32'd1) begin
					bytes_left_d = '0;
					state_d      = ST_HUNT;
				end else begin
					bytes_left_d = bytes_left_q - 32'd1;
				end
			end
			default: begin
				if (data_byte == sync_value_q) begin
					state_d = ST_TYPE;
				end else begin
					push           = 1'b1;
					push_item.kind = KIND_SYNC_ERR;
					state_d        = ST_HUNT;
				end
			end
		endcase
		push = push && accept;
	end

	// Frame state advances only on accepted bytes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_HUNT;
			held_type_q   <= '0;
			held_length_q <= '0;
			bytes_left_q  <= '0;
			len_idx_q     <= '0;
		end else if (accept) begin
			state_q       <= state_d;
			held_type_q   <= held_type_d;
			held_length_q <= held_length_d;
			bytes_left_q  <= bytes_left_d;
			len_idx_q     <= len_idx_d;
		end
	end

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_value_q   <= SYNC_VALUE_RST;
			length_limit_q <= LENGTH_LIMIT_RST;
		end else if (cfg_wr.valid) begin
			if (cfg_wr.index == REG_SYNC_VALUE) begin
				sync_value_q <= cfg_wr.data[7:0];
			end
			if (cfg_wr.index == REG_LENGTH_LIMIT) begin
				length_limit_q <= cfg_wr.data;
			end
		end
	end

endmodule

// File: hdl/stld_queue.sv
// Short result queue between the front end and the output stage.
// Depends on stld_pkg for the result item type.
module stld_queue #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  stld_pkg::result_t push_item,
	input  logic              pop,
	output logic              full,
	output logic              not_empty,
	output stld_pkg::result_t head_item
);
	import stld_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);

	result_t           entries_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]    count_q;
	logic              do_pop;

	assign full      = (count_q == (PTR_W + 1)'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head_item = entries_q[rd_ptr_q];
	assign do_pop    = pop && not_empty;

	// Pointers and fill count; DEPTH must be a power of two so pointers wrap (not checked here).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Item storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// File: hdl/stld_back.sv
// Output stage: holds one result item on the ports until it is taken.
// Depends on stld_pkg for the result item type.
module stld_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              not_empty,
	input  stld_pkg::result_t head_item,
	output logic              pop,
	input  logic              out_stall,
	output logic              out_valid,
	output stld_pkg::result_t out_item
);
	import stld_pkg::*;

	logic    out_valid_q;
	result_t out_item_q;
	logic    load;

	// The register reloads when empty or when its item is being taken.
	assign load      = !out_valid_q || !out_stall;
	assign pop       = load && not_empty;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= not_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_item_q <= head_item;
		end
	end

endmodule

// File: hdl/sync_type_length_deframer.sv
// Top level of the sync/type/length deframer: front end, result queue and
// output stage. Depends on stld_pkg, stld_front, stld_queue and stld_back.
//
//   Channel  Handshake             Payload
//   in       in_valid / in_stall   data_byte
//   out      out_valid / out_stall kind, frame_type, payload_byte,
//                                  last_of_frame, frame_length
//   cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One byte is accepted per cycle while in_stall is low; a result is written to the
// queue at the edge that accepts its byte and later loaded into the output register.
// The queue of QUEUE_DEPTH items sets how far the output may stall before
// in_stall rises; in_stall is the queue full flag.
// Reset is asynchronous and clears the frame state, queue and output valid.
// cfg_ready is always high.
module sync_type_length_deframer #(
	parameter int LENGTH_BYTES = 4,
	parameter int QUEUE_DEPTH  = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [7:0]                       data_byte,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [1:0]                       kind,
	output logic [7:0]                       frame_type,
	output logic [7:0]                       payload_byte,
	output logic                             last_of_frame,
	output logic [31:0]                      frame_length,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [stld_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]                      cfg_data
);
	import stld_pkg::*;

	cfg_wr_t cfg_wr;
	result_t push_item, head_item, out_item;
	logic    push, pop, full, not_empty;

	assign cfg_ready    = 1'b1;
	assign cfg_wr.valid = cfg_valid;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;
	assign in_stall     = full;

	stld_front #(
		.LENGTH_BYTES(LENGTH_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr   (cfg_wr),
		.in_valid (in_valid),
		.full     (full),
		.data_byte(data_byte),
		.push     (push),
		.push_item(push_item)
	);

	stld_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.full     (full),
		.not_empty(not_empty),
		.head_item(head_item)
	);

	stld_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.not_empty(not_empty),
		.head_item(head_item),
		.pop      (pop),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_item (out_item)
	);

	// Result fields on their own ports.
	assign kind          = out_item.kind;
	assign frame_type    = out_item.frame_type;
	assign payload_byte  = out_item.payload_byte;
	assign last_of_frame = out_item.last_of_frame;
	assign frame_length  = out_item.frame_length;

endmodule
